@@ design/assert_macros.svh @@
// Assertion macros shared by the design files.
// Each macro expands to one labeled concurrent assertion on clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SCSA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SCSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/scsa_pkg.sv @@
// Package of the slab allocator: sizes, codes, the slice record and the sequencer states.
// Depends on nothing; used by size_class_slab_allocator and the testbench.
package scsa_pkg;

    localparam int POOL_SLICES     = 128;
    localparam int SLICE_BYTES     = 4096;
    localparam int MIN_BLOCK_BYTES = 8;

    localparam int SLICE_W     = $clog2(POOL_SLICES);
    localparam int SLICE_SHIFT = $clog2(SLICE_BYTES);
    localparam int MIN_SHIFT   = $clog2(MIN_BLOCK_BYTES);
    localparam int BLOCKS_MAX  = SLICE_BYTES / MIN_BLOCK_BYTES;
    localparam int BLOCK_W     = $clog2(BLOCKS_MAX);
    localparam int LINK_W      = BLOCK_W + 1;
    localparam int USED_W      = BLOCK_W + 1;
    localparam int CLASS_COUNT = SLICE_SHIFT - MIN_SHIFT + 1;
    localparam int CLASS_W     = 4;
    localparam int SHIFT_W     = 5;
    localparam int SIZE_W      = 16;
    localparam int OFF_W       = 19;
    localparam int STEP_W      = SLICE_W + 1;
    localparam int LINK_AW     = SLICE_W + BLOCK_W;

    localparam logic [LINK_W-1:0] BLOCK_NULL = LINK_W'(BLOCKS_MAX);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_SLICE = 2'd1;
    localparam logic [1:0] STAT_TOO_BIG  = 2'd2;

    typedef struct packed {
        logic [CLASS_W-1:0] size_class;
        logic [USED_W-1:0]  used;
        logic [LINK_W-1:0]  head;
        logic [SLICE_W-1:0] next;
        logic [SLICE_W-1:0] prev;
    } slice_rec_t;

    localparam int REC_W = $bits(slice_rec_t);

    localparam slice_rec_t REC_RESET = '{
        size_class: '0, used: '0, head: BLOCK_NULL, next: '0, prev: '0
    };

    typedef enum logic [4:0] {
        ST_IDLE, ST_SIZE, ST_WRD, ST_WCHK, ST_LINK, ST_NEW, ST_STK, ST_THREAD,
        ST_PUSH, ST_PRD, ST_PWR, ST_FRD, ST_FCHK, ST_RPR, ST_RPW, ST_RNR,
        ST_RNW, ST_DONE
    } state_t;

endpackage

@@ design/scsa_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module scsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/size_class_slab_allocator.sv @@
// Top level of the size-class slab allocator: sequencer, class list heads and three RAMs.
// Depends on scsa_pkg, scsa_ram and assert_macros.svh.
//
//  Channel  Handshake            Beat contents
//  -------  -------------------  ------------------------------------------
//  in       in_valid / in_ready  command, request_size, free_offset
//  out      out_valid/out_ready  block_offset, status
//
// One item is in work at a time. A free reads its slice record and writes it back,
// then relinks the neighbours when the slice empties. An allocate rounds the size (an
// oversize one is refused there), walks its class list and pops a block; one that needs
// a new slice first threads a free list over every block of that slice (up to 512),
// written into the link RAM one entry a cycle, and pushes it on its class list.
// No clearing pass follows reset: slice records carry valid bits in flip-flops.
// A finished result waits in the output register; the next beat is taken meanwhile,
// and the sequencer stalls only when it has a second result ready to hand over.
`include "assert_macros.svh"

module size_class_slab_allocator
    import scsa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic [SIZE_W-1:0]  request_size,
    input  logic [OFF_W-1:0]   free_offset,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [OFF_W-1:0]   block_offset,
    output logic [1:0]         status
);

    // Sequencer registers.
    state_t             state_reg, state_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [CLASS_W-1:0] cls_reg, cls_next;
    logic [SLICE_W-1:0] slice_reg, slice_next;
    logic [SLICE_W-1:0] aux_reg, aux_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic [BLOCK_W-1:0] thr_reg, thr_next;
    slice_rec_t         rec_reg, rec_next;
    logic [STEP_W-1:0]  fcnt_reg, fcnt_next;
    logic [STEP_W-1:0]  fresh_reg, fresh_next;
    logic [OFF_W-1:0]   res_off_reg, res_off_next;
    logic [1:0]         res_st_reg, res_st_next;
    logic               out_valid_reg, out_valid_next;
    logic [OFF_W-1:0]   out_off_reg, out_off_next;
    logic [1:0]         out_st_reg, out_st_next;

    // Newest slice of every size class; zero is the empty list.
    logic [SLICE_W-1:0] heads_reg [CLASS_COUNT];
    logic               head_we;
    logic [CLASS_W-1:0] head_widx;
    logic [SLICE_W-1:0] head_wdata;

    // A slice record that was never written reads as the reset record.
    logic [POOL_SLICES-1:0] vld_reg;
    logic                   rvld_reg;

    // RAM ports.
    logic               sl_we;
    logic [SLICE_W-1:0] sl_waddr, sl_raddr;
    slice_rec_t         sl_wdata;
    logic [REC_W-1:0]   sl_rdata;
    slice_rec_t         cur_rec;

    logic               lk_we;
    logic [LINK_AW-1:0] lk_waddr, lk_raddr;
    logic [LINK_W-1:0]  lk_wdata, lk_rdata;

    logic               stk_we;
    logic [SLICE_W-1:0] stk_waddr, stk_raddr;
    logic [SLICE_W-1:0] stk_wdata, stk_rdata;

    // Helpers.
    logic [CLASS_W-1:0] size_cls;
    logic [SIZE_W-1:0]  size_m1;
    logic [SLICE_W-1:0] class_head;
    logic [BLOCK_W-1:0] thr_last;
    logic [SHIFT_W-1:0] blk_shift;
    logic [SHIFT_W-1:0] free_shift;
    logic [BLOCK_W-1:0] free_blk;
    logic [USED_W-1:0]  used_dec;
    logic [STEP_W-1:0]  steps_inc;

    scsa_ram #(.WIDTH(REC_W), .DEPTH(POOL_SLICES)) u_slice_ram (
        .clk   (clk),
        .we    (sl_we),
        .waddr (sl_waddr),
        .wdata (sl_wdata),
        .raddr (sl_raddr),
        .rdata (sl_rdata)
    );

    scsa_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLICES * BLOCKS_MAX)) u_link_ram (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .raddr (lk_raddr),
        .rdata (lk_rdata)
    );

    scsa_ram #(.WIDTH(SLICE_W), .DEPTH(POOL_SLICES)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign cur_rec = rvld_reg ? slice_rec_t'(sl_rdata) : REC_RESET;

    // Size class: log2 of the rounded block size over the minimum block size.
    assign size_m1 = size_reg - SIZE_W'(1);
    always_comb
    begin
        size_cls = '0;
        if (size_reg > SIZE_W'(MIN_BLOCK_BYTES))
        begin
            for (int i = 0; i < SIZE_W; i++)
            begin
                if (size_m1[i] && (i >= MIN_SHIFT))
                begin
                    size_cls = CLASS_W'(i + 1 - MIN_SHIFT);
                end
            end
        end
    end

    assign class_head = (cls_reg < CLASS_W'(CLASS_COUNT)) ? heads_reg[cls_reg] : '0;
    assign thr_last   = BLOCK_W'({BLOCK_W{1'b1}} >> cls_reg);
    assign blk_shift  = SHIFT_W'(cls_reg) + SHIFT_W'(MIN_SHIFT);
    assign free_shift = SHIFT_W'(cur_rec.size_class) + SHIFT_W'(MIN_SHIFT);
    assign free_blk   = BLOCK_W'(off_reg[SLICE_SHIFT-1:0] >> free_shift);
    assign used_dec   = cur_rec.used - USED_W'(1);
    assign steps_inc  = steps_reg + STEP_W'(1);

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign block_offset = out_off_reg;
    assign status       = out_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fcnt_reg      <= '0;
            fresh_reg     <= STEP_W'(1);
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
            rvld_reg      <= 1'b0;
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                heads_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            fcnt_reg      <= fcnt_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
            rvld_reg      <= vld_reg[sl_raddr];
            if (sl_we)
            begin
                vld_reg[sl_waddr] <= 1'b1;
            end
            if (head_we && (head_widx < CLASS_W'(CLASS_COUNT)))
            begin
                heads_reg[head_widx] <= head_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg    <= size_next;
        off_reg     <= off_next;
        cls_reg     <= cls_next;
        slice_reg   <= slice_next;
        aux_reg     <= aux_next;
        steps_reg   <= steps_next;
        thr_reg     <= thr_next;
        rec_reg     <= rec_next;
        res_off_reg <= res_off_next;
        res_st_reg  <= res_st_next;
        out_off_reg <= out_off_next;
        out_st_reg  <= out_st_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        off_next       = off_reg;
        cls_next       = cls_reg;
        slice_next     = slice_reg;
        aux_next       = aux_reg;
        steps_next     = steps_reg;
        thr_next       = thr_reg;
        rec_next       = rec_reg;
        fcnt_next      = fcnt_reg;
        fresh_next     = fresh_reg;
        res_off_next   = res_off_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_off_next   = out_off_reg;
        out_st_next    = out_st_reg;

        head_we    = 1'b0;
        head_widx  = cls_reg;
        head_wdata = slice_reg;

        sl_we    = 1'b0;
        sl_waddr = slice_reg;
        sl_wdata = cur_rec;
        sl_raddr = slice_reg;

        lk_we    = 1'b0;
        lk_waddr = {slice_reg, thr_reg};
        lk_wdata = BLOCK_NULL;
        lk_raddr = {slice_reg, cur_rec.head[BLOCK_W-1:0]};

        stk_we    = 1'b0;
        stk_waddr = fcnt_reg[SLICE_W-1:0];
        stk_wdata = slice_reg;
        stk_raddr = SLICE_W'(fcnt_reg - STEP_W'(1));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    size_next    = request_size;
                    off_next     = free_offset;
                    slice_next   = free_offset[OFF_W-1 -: SLICE_W];
                    res_off_next = '0;
                    res_st_next  = STAT_OK;
                    state_next   = (command == CMD_FREE) ? ST_FRD : ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                if (size_reg > SIZE_W'(SLICE_BYTES))
                begin
                    res_st_next = STAT_TOO_BIG;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cls_next   = size_cls;
                    slice_next = (size_cls < CLASS_W'(CLASS_COUNT)) ? heads_reg[size_cls] : '0;
                    steps_next = '0;
                    state_next = ST_WRD;
                end
            end
            ST_WRD:
            begin
                // Read the record of the slice under inspection.
                state_next = (slice_reg == '0) ? ST_NEW : ST_WCHK;
            end
            ST_WCHK:
            begin
                if (cur_rec.head != BLOCK_NULL)
                begin
                    rec_next   = cur_rec;
                    state_next = ST_LINK;
                end
                else if ((cur_rec.next == '0) || (steps_inc == STEP_W'(POOL_SLICES)))
                begin
                    state_next = ST_NEW;
                end
                else
                begin
                    slice_next = cur_rec.next;
                    steps_next = steps_inc;
                    state_next = ST_WRD;
                end
            end
            ST_LINK:
            begin
                // Pop the head block; its link is the new head.
                sl_we         = 1'b1;
                sl_wdata      = rec_reg;
                sl_wdata.head = lk_rdata;
                sl_wdata.used = rec_reg.used + USED_W'(1);
                res_off_next  = OFF_W'({slice_reg, {SLICE_SHIFT{1'b0}}})
                              + OFF_W'(OFF_W'(rec_reg.head[BLOCK_W-1:0]) << blk_shift);
                state_next    = ST_DONE;
            end
            ST_NEW:
            begin
                thr_next = '0;
                if (fcnt_reg != '0)
                begin
                    fcnt_next  = fcnt_reg - STEP_W'(1);
                    state_next = ST_STK;
                end
                else if (fresh_reg < STEP_W'(POOL_SLICES))
                begin
                    slice_next = fresh_reg[SLICE_W-1:0];
                    fresh_next = fresh_reg + STEP_W'(1);
                    state_next = ST_THREAD;
                end
                else
                begin
                    res_st_next = STAT_NO_SLICE;
                    state_next  = ST_DONE;
                end
            end
            ST_STK:
            begin
                slice_next = stk_rdata;
                state_next = ST_THREAD;
            end
            ST_THREAD:
            begin
                // Write one link of the new slice's sequential free list.
                lk_we    = 1'b1;
                lk_wdata = (thr_reg == thr_last) ? BLOCK_NULL : LINK_W'(thr_reg) + LINK_W'(1);
                if (thr_reg == thr_last)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    thr_next = thr_reg + BLOCK_W'(1);
                end
            end
            ST_PUSH:
            begin
                sl_we               = 1'b1;
                sl_wdata.size_class = cls_reg;
                sl_wdata.used       = '0;
                sl_wdata.head       = '0;
                sl_wdata.next       = class_head;
                sl_wdata.prev       = '0;
                head_we             = 1'b1;
                aux_next            = class_head;
                state_next          = (class_head != '0) ? ST_PRD : ST_WRD;
            end
            ST_PRD:
            begin
                sl_raddr   = aux_reg;
                state_next = ST_PWR;
            end
            ST_PWR:
            begin
                sl_we         = 1'b1;
                sl_waddr      = aux_reg;
                sl_wdata.prev = slice_reg;
                state_next    = ST_WRD;
            end
            ST_FRD:
            begin
                state_next = (slice_reg == '0) ? ST_DONE : ST_FCHK;
            end
            ST_FCHK:
            begin
                if (cur_rec.used == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    lk_we    = 1'b1;
                    lk_waddr = {slice_reg, free_blk};
                    lk_wdata = cur_rec.head;
                    sl_we    = 1'b1;
                    if (used_dec != '0)
                    begin
                        sl_wdata.head = LINK_W'(free_blk);
                        sl_wdata.used = used_dec;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        // Slice is empty: unlink it and hand it back to the pool.
                        sl_wdata.used = '0;
                        sl_wdata.head = BLOCK_NULL;
                        sl_wdata.next = '0;
                        sl_wdata.prev = '0;
                        rec_next      = cur_rec;
                        head_widx     = cur_rec.size_class;
                        head_wdata    = cur_rec.next;
                        head_we       = (cur_rec.size_class < CLASS_W'(CLASS_COUNT))
                                     && (heads_reg[cur_rec.size_class] == slice_reg);
                        if (fcnt_reg < STEP_W'(POOL_SLICES))
                        begin
                            stk_we    = 1'b1;
                            fcnt_next = fcnt_reg + STEP_W'(1);
                        end
                        if (cur_rec.prev != '0)
                        begin
                            state_next = ST_RPR;
                        end
                        else if (cur_rec.next != '0)
                        begin
                            state_next = ST_RNR;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_RPR:
            begin
                sl_raddr   = rec_reg.prev;
                state_next = ST_RPW;
            end
            ST_RPW:
            begin
                sl_we         = 1'b1;
                sl_waddr      = rec_reg.prev;
                sl_wdata.next = rec_reg.next;
                state_next    = (rec_reg.next != '0) ? ST_RNR : ST_DONE;
            end
            ST_RNR:
            begin
                sl_raddr   = rec_reg.next;
                state_next = ST_RNW;
            end
            ST_RNW:
            begin
                sl_we         = 1'b1;
                sl_waddr      = rec_reg.next;
                sl_wdata.prev = rec_reg.prev;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_off_next   = res_off_reg;
                    out_st_next    = res_st_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SCSA_ASSERT_IMP(a_fresh_bound, 1'b1, fresh_reg <= STEP_W'(POOL_SLICES),
        "fresh slice counter ran past the pool")
    `SCSA_ASSERT_IMP(a_stack_bound, 1'b1, fcnt_reg <= STEP_W'(POOL_SLICES),
        "freed slice stack overflowed")
    `SCSA_ASSERT_IMP(a_thread_range, state_reg == ST_THREAD, thr_reg <= thr_last,
        "free list threading left its slice")
    `SCSA_ASSERT_NEXT(a_result_src, out_valid_reg && out_ready && state_reg != ST_DONE,
        !out_valid_reg, "result appeared outside the done step")
    `SCSA_ASSERT_NEXT(a_alloc_start, in_valid && in_ready && command == CMD_ALLOC,
        state_reg == ST_SIZE, "allocate did not start with size rounding")

endmodule

@@ tb/size_class_slab_allocator_tb.sv @@
// Self-checking testbench of the size-class slab allocator.
// A table of directed beats is followed by random alloc/free traffic; every result
// is compared with an in-bench allocator model. Depends on scsa_pkg and the DUT only.
`timescale 1ns / 100ps

module size_class_slab_allocator_tb;
    import scsa_pkg::*;

    localparam int CLASS_SLOTS  = 16;
    localparam int LIMIT_CYCLES = 10000000;
    localparam int RANDOM_BEATS = 1830;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              command;
    logic [SIZE_W-1:0] request_size;
    logic [OFF_W-1:0]  free_offset;
    logic              out_valid;
    logic              out_ready;
    logic [OFF_W-1:0]  block_offset;
    logic [1:0]        status;

    size_class_slab_allocator DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .request_size(request_size), .free_offset(free_offset),
        .out_valid(out_valid), .out_ready(out_ready),
        .block_offset(block_offset), .status(status)
    );

    // Allocator model state; class, used and link fields use the block's own widths.
    logic [3:0]        mdl_class [POOL_SLICES];
    logic [USED_W-1:0] mdl_used  [POOL_SLICES];
    logic [LINK_W-1:0] mdl_head  [POOL_SLICES];
    logic [LINK_W-1:0] mdl_link  [POOL_SLICES*BLOCKS_MAX];
    logic [7:0]        mdl_next  [POOL_SLICES];
    logic [7:0]        mdl_prev  [POOL_SLICES];
    logic [7:0]        mdl_chead [CLASS_SLOTS];
    logic [7:0]        mdl_stack [POOL_SLICES];
    int                mdl_stack_cnt;
    int                mdl_fresh;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [1:0]       stat;
    } alloc_result_t;

    alloc_result_t pending_results[$];
    logic [OFF_W-1:0] live_blocks[$];   // offsets handed out and not yet freed
    int  mismatch_count;
    int  cycle_count;
    bit  no_idle;   // set for the closing stretch of the run

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want,
            cycle_count);
        mismatch_count++;
    endtask

    function automatic void model_reset();
        for (int i = 0; i < POOL_SLICES; i++)
        begin
            mdl_class[i] = '0;
            mdl_used[i]  = '0;
            mdl_head[i]  = BLOCK_NULL;
            mdl_next[i]  = '0;
            mdl_prev[i]  = '0;
            mdl_stack[i] = '0;
        end
        for (int i = 0; i < POOL_SLICES*BLOCKS_MAX; i++)
            mdl_link[i] = '0;
        for (int i = 0; i < CLASS_SLOTS; i++)
            mdl_chead[i] = '0;
        mdl_stack_cnt = 0;
        mdl_fresh = 1;
    endfunction

    function automatic alloc_result_t model_alloc(input int size);
        alloc_result_t r;
        int bsz, cls, s, steps, n, b;
        bsz = MIN_BLOCK_BYTES;
        cls = 0;
        r = '0;
        while (bsz < size)
        begin
            bsz = bsz << 1;
            cls++;
        end
        if (bsz > SLICE_BYTES)
        begin
            r.stat = STAT_TOO_BIG;
            return r;
        end
        s = mdl_chead[cls];
        for (steps = 0; s != 0 && steps < POOL_SLICES; steps++)
        begin
            if (mdl_head[s] != BLOCK_NULL)
                break;
            s = mdl_next[s];
        end
        if (s == 0 || steps >= POOL_SLICES)
        begin
            if (mdl_stack_cnt > 0)
            begin
                mdl_stack_cnt--;
                s = mdl_stack[mdl_stack_cnt];
            end
            else if (mdl_fresh < POOL_SLICES)
            begin
                s = mdl_fresh;
                mdl_fresh++;
            end
            else
            begin
                r.stat = STAT_NO_SLICE;
                return r;
            end
            n = SLICE_BYTES / bsz;
            for (int i = 0; i < n; i++)
                mdl_link[s*BLOCKS_MAX + i] = (i + 1 < n) ? LINK_W'(i + 1) : BLOCK_NULL;
            mdl_head[s] = '0;
            mdl_used[s] = '0;
            mdl_class[s] = 4'(cls);
            // Push the new slice at the head of its class list.
            mdl_prev[s] = '0;
            mdl_next[s] = mdl_chead[cls];
            if (mdl_chead[cls] != 0)
                mdl_prev[mdl_chead[cls]] = 8'(s);
            mdl_chead[cls] = 8'(s);
        end
        b = mdl_head[s] % BLOCKS_MAX;
        mdl_head[s] = mdl_link[s*BLOCKS_MAX + b];
        mdl_used[s]++;
        r.stat = STAT_OK;
        r.offset = OFF_W'(s * SLICE_BYTES + b * bsz);
        return r;
    endfunction

    function automatic void model_free(input int off);
        int s, bsz, b, cls, p, n;
        s = off / SLICE_BYTES;
        if (s == 0 || s >= POOL_SLICES || mdl_used[s] == 0)
            return;
        bsz = MIN_BLOCK_BYTES << mdl_class[s];
        b = ((off % SLICE_BYTES) / bsz) % BLOCKS_MAX;
        mdl_link[s*BLOCKS_MAX + b] = mdl_head[s];
        mdl_head[s] = LINK_W'(b);
        mdl_used[s]--;
        if (mdl_used[s] == 0)
        begin
            cls = mdl_class[s];
            p = mdl_prev[s];
            n = mdl_next[s];
            if (p != 0)
                mdl_next[p] = 8'(n);
            if (n != 0)
                mdl_prev[n] = 8'(p);
            if (mdl_chead[cls] == s)
                mdl_chead[cls] = 8'(n);
            mdl_next[s] = '0;
            mdl_prev[s] = '0;
            if (mdl_stack_cnt < POOL_SLICES)
            begin
                mdl_stack[mdl_stack_cnt] = 8'(s);
                mdl_stack_cnt++;
            end
            mdl_head[s] = BLOCK_NULL;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: compare each accepted beat with the oldest expectation.
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result beat", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (block_offset !== want.offset)
                    report_mismatch("block_offset", block_offset, want.offset);
                if (status !== want.stat)
                    report_mismatch("status", status, want.stat);
            end
        end
    end

    // Receiver stalls come in random bursts until the closing stretch.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                gap = $urandom_range(1, 19);
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Drives one beat at the falling edge and holds it until the DUT takes it.
    // Valid stays high into the next beat unless an idle burst comes first.
    // The expectation comes from the model, or from the typed-in value when one is given.
    task automatic send_beat(input logic cmd, input int size, input int off,
                             input bit typed, input alloc_result_t typed_res);
        alloc_result_t r;
        int gap;
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        command      <= cmd;
        request_size <= SIZE_W'(size);
        free_offset  <= OFF_W'(off);
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = '0;
        if (cmd == CMD_ALLOC)
        begin
            r = model_alloc(size & 16'hFFFF);
            if (r.stat == STAT_OK)
                live_blocks.push_back(r.offset);
        end
        else
            model_free(off & 19'h7FFFF);
        if (typed && r != typed_res)
            report_mismatch("model vs table", r, typed_res);
        pending_results.push_back(r);
        @(negedge clk);
    endtask

    typedef struct {
        logic cmd;
        int   size;
        int   off;
        bit   typed;
        alloc_result_t res;
    } stim_row_t;

    // Directed beats. Known results are typed in for a freshly reset pool.
    stim_row_t directed_rows[] = '{
        '{CMD_ALLOC, 0,     0,      1, '{19'h01000, STAT_OK}},   // zero size
        '{CMD_ALLOC, 1,     0,      1, '{19'h01008, STAT_OK}},
        '{CMD_ALLOC, 8,     0,      1, '{19'h01010, STAT_OK}},
        '{CMD_ALLOC, 9,     0,      1, '{19'h02000, STAT_OK}},   // new class
        '{CMD_ALLOC, 4096,  0,      1, '{19'h03000, STAT_OK}},   // whole slice
        '{CMD_ALLOC, 4097,  0,      1, '{19'h0,     STAT_TOO_BIG}},
        '{CMD_ALLOC, 65535, 0,      1, '{19'h0,     STAT_TOO_BIG}},
        '{CMD_FREE,  0,     0,      1, '{19'h0,     STAT_OK}},   // reserved slice
        '{CMD_FREE,  0,     19'h7FFFF, 1, '{19'h0,  STAT_OK}},   // top slice, idle
        '{CMD_FREE,  0,     19'h05000, 1, '{19'h0,  STAT_OK}},   // idle slice
        '{CMD_FREE,  65535, 19'h03000, 0, '{19'h0,  STAT_OK}},   // returns slice 3
        '{CMD_ALLOC, 2048,  0,      0, '{19'h0,     STAT_OK}},   // reuses slice 3
        '{CMD_FREE,  0,     19'h0100B, 0, '{19'h0,  STAT_OK}},   // unaligned
        '{CMD_ALLOC, 7,     19'h7FFFF, 0, '{19'h0,  STAT_OK}},
        '{CMD_FREE,  0,     19'h02000, 0, '{19'h0,  STAT_OK}},
        '{CMD_FREE,  0,     19'h02000, 0, '{19'h0,  STAT_OK}},   // double free
        '{CMD_ALLOC, 16,    0,      0, '{19'h0,     STAT_OK}},
        '{CMD_ALLOC, 100,   0,      0, '{19'h0,     STAT_OK}},
        '{CMD_ALLOC, 1000,  0,      0, '{19'h0,     STAT_OK}}
    };

    initial
    begin
        alloc_result_t none;
        int pick, sz, drain;
        mismatch_count = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        none = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_ALLOC;
        request_size = '0;
        free_offset = '0;
        model_reset();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].cmd, directed_rows[i].size, directed_rows[i].off,
                directed_rows[i].typed, directed_rows[i].res);
        // The directed rows left double-freed blocks behind; forget them.
        live_blocks.delete();

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n > RANDOM_BEATS - 150)
                no_idle = 1'b1;
            // Mostly small classes keep slice threading short; large sizes are rare.
            case ($urandom_range(0, 19))
                0: sz = $urandom_range(0, 65535);
                1, 2: sz = $urandom_range(513, 4096);
                default: sz = $urandom_range(0, 512);
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 50 || (live_blocks.size() == 0 && pick < 90))
                send_beat(CMD_ALLOC, sz, $urandom, 0, none);
            else if (pick < 90)
            begin
                // Free a live block, sometimes unaligned within it.
                pick = $urandom_range(0, live_blocks.size() - 1);
                send_beat(CMD_FREE, $urandom, live_blocks[pick] | $urandom_range(0, 7),
                    0, none);
                live_blocks.delete(pick);
            end
            else
                send_beat(CMD_FREE, $urandom, $urandom_range(0, 524287), 0, none);
        end
        in_valid <= 1'b0;

        drain = 0;
        while (pending_results.size() != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (600) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/scsa_pkg.sv
design/scsa_ram.sv
design/size_class_slab_allocator.sv
tb/size_class_slab_allocator_tb.sv
